// ===== rtl/one_wire_temp_sensor_master_top_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ONE_WIRE_TEMP_SENSOR_MASTER_TOP_MACROS_SVH
`define ONE_WIRE_TEMP_SENSOR_MASTER_TOP_MACROS_SVH

`ifndef SYNTH
// Concurrent assertion on an explicit clock and active-low reset
`define OWTSM_ASSERT_CR(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Concurrent assertion on the block clock and reset
`define OWTSM_ASSERT(label, prop, msg) \
  `OWTSM_ASSERT_CR(label, clk_i, rst_ni, prop, msg)
`else
`define OWTSM_ASSERT_CR(label, clk, rstn, prop, msg)
`define OWTSM_ASSERT(label, prop, msg)
`endif

`endif

// ===== rtl/owtsm_pkg.sv =====
package owtsm_pkg;

  // Operation kinds of one sequence step
  typedef enum logic [2:0] {
    OP_NONE,
    OP_RESET,
    OP_WCONST,
    OP_WRES,
    OP_READ
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [7:0]  data;
  } op_t;

  // Request codes
  typedef enum logic [1:0] {
    REQ_TICK,
    REQ_CONVERT,
    REQ_SET_RES,
    REQ_READ_TEMP
  } req_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RESET_LOW,
    CFG_RESET_WAIT,
    CFG_WRITE_SLOT,
    CFG_READ_RECOVERY
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Bus commands and fixed bytes
  localparam logic [7:0] CMD_SKIP_ROM      = 8'hCC;
  localparam logic [7:0] CMD_CONVERT       = 8'h44;
  localparam logic [7:0] CMD_WRITE_SCRATCH = 8'h4E;
  localparam logic [7:0] CMD_COPY_SCRATCH  = 8'h48;
  localparam logic [7:0] CMD_READ_SCRATCH  = 8'hBE;
  localparam logic [7:0] ALARM_BYTE        = 8'h00;

  // Configuration reset values
  localparam logic [7:0] RESET_LOW_DEFAULT     = 8'd200;
  localparam logic [7:0] RESET_WAIT_DEFAULT    = 8'd100;
  localparam logic [7:0] WRITE_SLOT_DEFAULT    = 8'd30;
  localparam logic [7:0] READ_RECOVERY_DEFAULT = 8'd20;

  typedef struct packed {
    logic [7:0] reset_low;
    logic [7:0] reset_wait;
    logic [7:0] write_slot;
    logic [7:0] read_recovery;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic               bus_drive;
    logic               busy;
    logic               done;
    logic signed [15:0] temp_raw;
    logic               temp_valid;
  } result_t;

  // Outcome of one tick of a timed phase
  typedef struct packed {
    logic       done;
    logic [7:0] tick;
  } phase_t;

  function automatic op_t mk_op(op_kind_e kind, logic [7:0] data);
    op_t op;
    op.kind = kind;
    op.data = data;
    return op;
  endfunction

  // Operation list of each request, steps counted from one
  function automatic op_t op_lookup(req_e req, logic [3:0] step);
    op_t op;
    op = mk_op(OP_NONE, 8'h00);
    case (req)
      REQ_CONVERT: begin
        case (step)
          4'd1:    op = mk_op(OP_RESET, 8'h00);
          4'd2:    op = mk_op(OP_WCONST, CMD_SKIP_ROM);
          4'd3:    op = mk_op(OP_WCONST, CMD_CONVERT);
          default: op = mk_op(OP_NONE, 8'h00);
        endcase
      end
      REQ_SET_RES: begin
        case (step)
          4'd1:    op = mk_op(OP_RESET, 8'h00);
          4'd2:    op = mk_op(OP_WCONST, CMD_SKIP_ROM);
          4'd3:    op = mk_op(OP_WCONST, CMD_WRITE_SCRATCH);
          4'd4:    op = mk_op(OP_WCONST, ALARM_BYTE);
          4'd5:    op = mk_op(OP_WCONST, ALARM_BYTE);
          4'd6:    op = mk_op(OP_WRES, 8'h00);
          4'd7:    op = mk_op(OP_RESET, 8'h00);
          4'd8:    op = mk_op(OP_WCONST, CMD_SKIP_ROM);
          4'd9:    op = mk_op(OP_WCONST, CMD_COPY_SCRATCH);
          default: op = mk_op(OP_NONE, 8'h00);
        endcase
      end
      REQ_READ_TEMP: begin
        case (step)
          4'd1:    op = mk_op(OP_RESET, 8'h00);
          4'd2:    op = mk_op(OP_WCONST, CMD_SKIP_ROM);
          4'd3:    op = mk_op(OP_WCONST, CMD_READ_SCRATCH);
          4'd4:    op = mk_op(OP_READ, 8'h00);
          4'd5:    op = mk_op(OP_READ, 8'h00);
          default: op = mk_op(OP_NONE, 8'h00);
        endcase
      end
      default: op = mk_op(OP_NONE, 8'h00);
    endcase
    return op;
  endfunction

  // Count one tick of a phase; a length of zero acts as one tick
  function automatic phase_t phase_step(logic [7:0] tick, logic [7:0] len);
    logic [8:0] t;
    logic [7:0] l;
    phase_t     p;
    l = (len == 8'd0) ? 8'd1 : len;
    t = {1'b0, tick} + 9'd1;
    if (t >= {1'b0, l}) begin
      p.done = 1'b1;
      p.tick = 8'd0;
    end else begin
      p.done = 1'b0;
      p.tick = t[7:0];
    end
    return p;
  endfunction

endpackage

// ===== rtl/owtsm_core.sv =====
`include "one_wire_temp_sensor_master_top_macros.svh"

module owtsm_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  logic [1:0]        req_i,
  input  logic [7:0]        res_byte_i,
  input  logic              bus_i,
  input  owtsm_pkg::cfg_t   cfg_i,
  output owtsm_pkg::result_t result_o
);
  import owtsm_pkg::*;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;
  localparam logic [1:0] PH_FOURTH = 2'd3;

  logic [3:0]  seq_q, seq_d;
  req_e        act_q, act_d;
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  tick_q, tick_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  held_q, held_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] temp_q, temp_d;

  // Advance the sequencer by one tick
  always_comb begin
    op_t        op_now;
    op_t        op_next;
    phase_t     ph;
    logic [3:0] seq_inc;
    logic       step_end;
    logic       drive;
    logic       busy;
    logic       done;
    logic       valid;

    seq_d    = seq_q;
    act_d    = act_q;
    phase_d  = phase_q;
    bit_d    = bit_q;
    tick_d   = tick_q;
    shift_d  = shift_q;
    held_d   = held_q;
    low_d    = low_q;
    temp_d   = temp_q;
    ph       = '0;
    step_end = 1'b0;
    drive    = 1'b1;
    busy     = 1'b0;
    done     = 1'b0;
    valid    = 1'b0;

    // Latch a new request on an idle tick
    if (seq_q == 4'd0 && req_i != 2'd0) begin
      act_d   = req_e'(req_i);
      held_d  = res_byte_i;
      seq_d   = 4'd1;
      op_now  = op_lookup(act_d, seq_d);
      case (op_now.kind)
        OP_WCONST: shift_d = op_now.data;
        OP_WRES:   shift_d = held_d;
        default:   shift_d = 8'h00;
      endcase
      phase_d = PH_FIRST;
      tick_d  = 8'd0;
      bit_d   = 3'd0;
    end

    op_now = op_lookup(act_d, seq_d);
    if (seq_d != 4'd0 && op_now.kind == OP_NONE) begin
      seq_d = 4'd0;
    end

    seq_inc = seq_d + 4'd1;
    op_next = op_lookup(act_d, seq_inc);

    if (seq_d != 4'd0) begin
      busy = 1'b1;
      case (op_now.kind)
        // Reset pulse, then release
        OP_RESET: begin
          if (phase_d == PH_FIRST) begin
            drive  = 1'b0;
            ph     = phase_step(tick_d, cfg_i.reset_low);
            tick_d = ph.tick;
            if (ph.done) begin
              phase_d = PH_SECOND;
            end
          end else begin
            drive  = 1'b1;
            ph     = phase_step(tick_d, cfg_i.reset_wait);
            tick_d = ph.tick;
            if (ph.done) begin
              step_end = 1'b1;
            end
          end
        end
        // Read slot: low, release, sample, recover
        OP_READ: begin
          case (phase_d)
            PH_FIRST: begin
              drive   = 1'b0;
              phase_d = PH_SECOND;
            end
            PH_SECOND: begin
              drive   = 1'b1;
              phase_d = PH_THIRD;
            end
            PH_THIRD: begin
              drive   = 1'b1;
              shift_d = {bus_i, shift_d[7:1]};
              phase_d = PH_FOURTH;
            end
            default: begin
              drive  = 1'b1;
              ph     = phase_step(tick_d, cfg_i.read_recovery);
              tick_d = ph.tick;
              if (ph.done) begin
                phase_d = PH_FIRST;
                tick_d  = 8'd0;
                if (bit_d == 3'd7) begin
                  bit_d    = 3'd0;
                  step_end = 1'b1;
                  if (op_next.kind == OP_NONE) begin
                    temp_d = {shift_d, low_d};
                    valid  = 1'b1;
                  end else begin
                    low_d = shift_d;
                  end
                end else begin
                  bit_d = bit_d + 3'd1;
                end
              end
            end
          endcase
        end
        // Write slot: low, data bit, release
        default: begin
          case (phase_d)
            PH_FIRST: begin
              drive   = 1'b0;
              phase_d = PH_SECOND;
            end
            PH_SECOND: begin
              drive  = shift_d[0];
              ph     = phase_step(tick_d, cfg_i.write_slot);
              tick_d = ph.tick;
              if (ph.done) begin
                phase_d = PH_THIRD;
              end
            end
            default: begin
              drive   = 1'b1;
              shift_d = {1'b0, shift_d[7:1]};
              phase_d = PH_FIRST;
              tick_d  = 8'd0;
              if (bit_d == 3'd7) begin
                bit_d    = 3'd0;
                step_end = 1'b1;
              end else begin
                bit_d = bit_d + 3'd1;
              end
            end
          endcase
        end
      endcase

      // Move to the next operation or finish
      if (step_end) begin
        phase_d = PH_FIRST;
        tick_d  = 8'd0;
        bit_d   = 3'd0;
        if (op_next.kind == OP_NONE) begin
          seq_d = 4'd0;
          done  = 1'b1;
        end else begin
          seq_d = seq_inc;
          case (op_next.kind)
            OP_WCONST: shift_d = op_next.data;
            OP_WRES:   shift_d = held_d;
            default:   shift_d = 8'h00;
          endcase
        end
      end
    end

    result_o.bus_drive  = drive;
    result_o.busy       = busy;
    result_o.done       = done;
    result_o.temp_raw   = $signed(temp_d);
    result_o.temp_valid = valid;
  end

  // Hold state between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= 4'd0;
      act_q   <= REQ_TICK;
      phase_q <= PH_FIRST;
      bit_q   <= 3'd0;
      tick_q  <= 8'd0;
      shift_q <= 8'h00;
      held_q  <= 8'h00;
      low_q   <= 8'h00;
      temp_q  <= 16'h0000;
    end else if (step_en_i) begin
      seq_q   <= seq_d;
      act_q   <= act_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      held_q  <= held_d;
      low_q   <= low_d;
      temp_q  <= temp_d;
    end
  end

  `OWTSM_ASSERT(a_idle_stays, step_en_i && seq_q == 4'd0 && req_i == 2'd0 |=> seq_q == 4'd0, "idle tick without request left idle")
  `OWTSM_ASSERT(a_valid_done, result_o.temp_valid |-> result_o.done && result_o.busy, "temperature valid outside sequence end")
  `OWTSM_ASSERT(a_hold_state, !step_en_i |=> $stable(seq_q) && $stable(temp_q), "state moved without an item")

endmodule

// ===== rtl/one_wire_temp_sensor_master_top.sv =====
// Latency: a result item is presented the cycle after its input item is accepted.
// Throughput: one item (one bus tick) per cycle; input ready stays high while
// the output register is empty or being drained the same cycle.
// Reset: timing registers return to 200/100/30/20 ticks, the sequencer goes idle,
// the stored temperature clears to zero and no result is pending.
`include "one_wire_temp_sensor_master_top_macros.svh"

module one_wire_temp_sensor_master_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             req_type_i,
  input  logic [7:0]                             resolution_byte_i,
  input  logic                                   bus_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   bus_drive_o,
  output logic                                   busy_res_o,
  output logic                                   done_res_o,
  output logic signed [15:0]                     temp_raw_o,
  output logic                                   temp_valid_o,
  input  logic                                   cfg_we_i,
  input  logic [owtsm_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [owtsm_pkg::CfgDataW-1:0]         cfg_wdata_i
);
  import owtsm_pkg::*;

  cfg_t    cfg_q;
  result_t res_d;
  result_t res_q;
  logic    out_valid_q;
  logic    accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Write timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low     <= RESET_LOW_DEFAULT;
      cfg_q.reset_wait    <= RESET_WAIT_DEFAULT;
      cfg_q.write_slot    <= WRITE_SLOT_DEFAULT;
      cfg_q.read_recovery <= READ_RECOVERY_DEFAULT;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RESET_LOW:     cfg_q.reset_low     <= cfg_wdata_i;
        CFG_RESET_WAIT:    cfg_q.reset_wait    <= cfg_wdata_i;
        CFG_WRITE_SLOT:    cfg_q.write_slot    <= cfg_wdata_i;
        CFG_READ_RECOVERY: cfg_q.read_recovery <= cfg_wdata_i;
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  owtsm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (accept),
    .req_i      (req_type_i),
    .res_byte_i (resolution_byte_i),
    .bus_i      (bus_in_i),
    .cfg_i      (cfg_q),
    .result_o   (res_d)
  );

  // Track a pending result item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bus_drive_o  = res_q.bus_drive;
  assign busy_res_o   = res_q.busy;
  assign done_res_o   = res_q.done;
  assign temp_raw_o   = res_q.temp_raw;
  assign temp_valid_o = res_q.temp_valid;

  `OWTSM_ASSERT(a_accept_shows, accept |=> out_valid_o, "accepted item produced no result")
  `OWTSM_ASSERT(a_done_busy, out_valid_o && done_res_o |-> busy_res_o, "done without busy")
  `OWTSM_ASSERT(a_held_result, out_valid_o && !out_ready_i |=> $stable(res_q), "pending result changed")

endmodule
